### hw/rtl/xprf_pkg.sv
// Package for the partial-register file: register id decoding, lane codes,
// controller states and the command and status structs. No dependencies.
`default_nettype none
package xprf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SEG_W     = 16;
  localparam int unsigned ID_W      = 5;
  localparam int unsigned GEN_COUNT = 8;
  localparam int unsigned SEG_COUNT = 6;
  localparam int unsigned SLOT_W    = 3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // First and last id of each group of register names.
  localparam logic [ID_W-1:0] ID_DWORD_FIRST = 5'd1;
  localparam logic [ID_W-1:0] ID_DWORD_LAST  = 5'd8;
  localparam logic [ID_W-1:0] ID_WORD_FIRST  = 5'd9;
  localparam logic [ID_W-1:0] ID_WORD_LAST   = 5'd16;
  localparam logic [ID_W-1:0] ID_LOW_FIRST   = 5'd17;
  localparam logic [ID_W-1:0] ID_LOW_LAST    = 5'd20;
  localparam logic [ID_W-1:0] ID_HIGH_FIRST  = 5'd21;
  localparam logic [ID_W-1:0] ID_HIGH_LAST   = 5'd24;
  localparam logic [ID_W-1:0] ID_SEG_FIRST   = 5'd25;
  localparam logic [ID_W-1:0] ID_SEG_LAST    = 5'd30;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_GENERAL,
    KIND_SEGMENT
  } kind_t;

  typedef enum logic [1:0] {
    LANE_DWORD,
    LANE_WORD,
    LANE_LOW_BYTE,
    LANE_HIGH_BYTE
  } lane_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    lane_t             lane;
  } loc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic execute;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
  } dp_status_t;

  function automatic loc_t decode_id(input logic [ID_W-1:0] id);
    loc_t             loc;
    logic [ID_W-1:0]  diff;
    loc.kind = KIND_NONE;
    loc.slot = '0;
    loc.lane = LANE_DWORD;
    diff     = '0;
    if (id >= ID_DWORD_FIRST && id <= ID_DWORD_LAST) begin
      diff     = id - ID_DWORD_FIRST;
      loc.kind = KIND_GENERAL;
      loc.lane = LANE_DWORD;
    end else if (id >= ID_WORD_FIRST && id <= ID_WORD_LAST) begin
      diff     = id - ID_WORD_FIRST;
      loc.kind = KIND_GENERAL;
      loc.lane = LANE_WORD;
    end else if (id >= ID_LOW_FIRST && id <= ID_LOW_LAST) begin
      diff     = id - ID_LOW_FIRST;
      loc.kind = KIND_GENERAL;
      loc.lane = LANE_LOW_BYTE;
    end else if (id >= ID_HIGH_FIRST && id <= ID_HIGH_LAST) begin
      diff     = id - ID_HIGH_FIRST;
      loc.kind = KIND_GENERAL;
      loc.lane = LANE_HIGH_BYTE;
    end else if (id >= ID_SEG_FIRST && id <= ID_SEG_LAST) begin
      diff     = id - ID_SEG_FIRST;
      loc.kind = KIND_SEGMENT;
      loc.lane = LANE_WORD;
    end
    loc.slot = diff[SLOT_W-1:0];
    return loc;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/xprf_datapath.sv
// Datapath of the partial-register file: the register storage, the captured
// transaction and the result register. Depends on xprf_pkg.
`default_nettype none
module xprf_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire xprf_pkg::dp_cmd_t           cmd,
  output xprf_pkg::dp_status_t             status,
  input  wire logic                        command,
  input  wire logic [xprf_pkg::ID_W-1:0]   register_id,
  input  wire logic [xprf_pkg::DATA_W-1:0] write_value,
  output logic [xprf_pkg::DATA_W-1:0]      read_value
);
  import xprf_pkg::*;

  logic [DATA_W-1:0] general_regs [GEN_COUNT];
  logic [SEG_W-1:0]  segment_regs [SEG_COUNT];

  logic              command_q;
  loc_t              loc_q;
  logic [DATA_W-1:0] value_q;

  logic [DATA_W-1:0] gen_cur;
  logic [DATA_W-1:0] gen_next;
  logic [DATA_W-1:0] read_next;

  assign status.is_read = (command_q == CMD_READ);

  // Transaction capture; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_q <= command;
      loc_q     <= decode_id(register_id);
      value_q   <= write_value;
    end
  end

  assign gen_cur = general_regs[loc_q.slot];

  always_comb begin
    gen_next = gen_cur;
    case (loc_q.lane)
      LANE_DWORD:     gen_next = value_q;
      LANE_WORD:      gen_next[15:0] = value_q[15:0];
      LANE_LOW_BYTE:  gen_next[7:0] = value_q[7:0];
      LANE_HIGH_BYTE: gen_next[15:8] = value_q[7:0];
      default:        gen_next = gen_cur;
    endcase
  end

  always_comb begin
    read_next = '0;
    case (loc_q.kind)
      KIND_GENERAL: begin
        case (loc_q.lane)
          LANE_DWORD:     read_next = gen_cur;
          LANE_WORD:      read_next = {16'h0000, gen_cur[15:0]};
          LANE_LOW_BYTE:  read_next = {24'h000000, gen_cur[7:0]};
          LANE_HIGH_BYTE: read_next = {24'h000000, gen_cur[15:8]};
          default:        read_next = '0;
        endcase
      end
      KIND_SEGMENT: read_next = {{(DATA_W-SEG_W){1'b0}}, segment_regs[loc_q.slot]};
      default:      read_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GEN_COUNT; i++) general_regs[i] <= '0;
      for (int i = 0; i < SEG_COUNT; i++) segment_regs[i] <= '0;
    end else if (cmd.execute && command_q == CMD_WRITE) begin
      case (loc_q.kind)
        KIND_GENERAL: general_regs[loc_q.slot] <= gen_next;
        KIND_SEGMENT: segment_regs[loc_q.slot] <= value_q[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && command_q == CMD_READ) begin
      read_value <= read_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/xprf_controller.sv
// Controller of the partial-register file: sequences capture, execution and
// delivery of one transaction at a time. Depends on xprf_pkg.
`default_nettype none
module xprf_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output xprf_pkg::dp_cmd_t         cmd,
  input  wire xprf_pkg::dp_status_t status
);
  import xprf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = status.is_read ? ST_SEND : ST_IDLE;
      ST_SEND: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: cmd.execute = 1'b1;
      ST_SEND: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/x86_partial_register_file_unit.sv
// Top level of the partial-register file: joins the controller and datapath.
// Depends on xprf_pkg, xprf_controller and xprf_datapath.
`default_nettype none
// Usage.
// The input channel (in_valid, in_stall, command, register_id, write_value)
// carries one read or write transaction naming a register id: whole 32-bit
// registers, their low halves, their low and high bytes, or a segment
// register. Id none and the unused code read as zero and ignore writes.
// A read gives one transaction on the output channel (out_valid, out_stall,
// read_value) holding the named bits zero-extended; a write gives none.
// Sequence: a transaction is captured in the accepting cycle, executed in
// the controller's execute state, and a read result is then offered from its
// send state; a write gives no result. The controller runs the sequence
// capture, execute, send, and handles one transaction at a time.
// While a result waits, in_stall stays high; the result and out_valid hold
// steady for as long as out_stall is high, and no new input is taken.
// A synchronous reset clears every general and segment register to zero and
// returns the controller to idle; the block is ready on the following cycle.
module x86_partial_register_file_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        command,
  input  wire logic [xprf_pkg::ID_W-1:0]   register_id,
  input  wire logic [xprf_pkg::DATA_W-1:0] write_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [xprf_pkg::DATA_W-1:0]      read_value
);
  import xprf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller decides when the datapath captures and executes.
  xprf_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the registers and applies the byte-lane merges.
  xprf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .register_id (register_id),
    .write_value (write_value),
    .read_value  (read_value)
  );

endmodule
`default_nettype wire

### hw/rtl/xprf_checker.sv
// Port-level checks of the partial-register file, bound to the top level.
// Depends on x86_partial_register_file_unit's ports only.
`default_nettype none
module xprf_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] read_value
);

  // A result on offer blocks new input until it is taken.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // A result never appears in the cycle straight after an accepted input.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result offered too early");

  // Reset leaves no result on offer.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result stays on offer with the same value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_value)))
    else $error("stalled result changed");

endmodule

bind x86_partial_register_file_unit xprf_port_checks u_xprf_port_checks (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_value (read_value)
);
`default_nettype wire

### bench/xprf_checker.sv
// Checker for the partial-register file: watches both channels, keeps its own
// copy of the general and segment registers and compares every read result.
// Depends on xprf_pkg.
module xprf_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        command,
  input  wire logic [xprf_pkg::ID_W-1:0]   register_id,
  input  wire logic [xprf_pkg::DATA_W-1:0] write_value,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [xprf_pkg::DATA_W-1:0] read_value,
  input  wire logic                        run_done,
  output int unsigned                      mismatch_count,
  output int unsigned                      reads_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import xprf_pkg::*;

  // Where a register id lands: which file, which entry, and which bits.
  typedef struct {
    kind_t             kind;
    int unsigned       slot;
    int unsigned       shift;
    logic [DATA_W-1:0] mask;
  } alias_view_t;

  logic [DATA_W-1:0] gpr_shadow [GEN_COUNT];
  logic [SEG_W-1:0]  sreg_shadow [SEG_COUNT];
  logic [DATA_W-1:0] pending_reads [$];
  logic              leftover_checked = 1'b0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : track
    alias_view_t       view;
    logic [DATA_W-1:0] lane_bits;
    logic [DATA_W-1:0] wanted;
    if (rst) begin
      for (int i = 0; i < GEN_COUNT; i++) gpr_shadow[i] = '0;
      for (int i = 0; i < SEG_COUNT; i++) sreg_shadow[i] = '0;
      pending_reads.delete();
      reads_in_flight <= 0;
    end else begin
      // The result side is looked at first, so a read accepted in this cycle
      // can never be matched against a result offered in the same cycle.
      if (out_valid && !out_stall) begin
        if (pending_reads.size() == 0) begin
          report_mismatch($sformatf("result %h with no read outstanding", read_value));
        end else begin
          wanted = pending_reads.pop_front();
          if (read_value !== wanted)
            report_mismatch($sformatf("read_value %h, expected %h", read_value, wanted));
        end
      end

      if (in_valid && !in_stall) begin
        view.kind  = KIND_NONE;
        view.slot  = 0;
        view.shift = 0;
        view.mask  = '0;
        if (register_id >= ID_DWORD_FIRST && register_id <= ID_DWORD_LAST) begin
          view.kind = KIND_GENERAL;
          view.slot = 32'(register_id - ID_DWORD_FIRST);
          view.mask = 32'hffff_ffff;
        end else if (register_id >= ID_WORD_FIRST && register_id <= ID_WORD_LAST) begin
          view.kind = KIND_GENERAL;
          view.slot = 32'(register_id - ID_WORD_FIRST);
          view.mask = 32'h0000_ffff;
        end else if (register_id >= ID_LOW_FIRST && register_id <= ID_LOW_LAST) begin
          view.kind = KIND_GENERAL;
          view.slot = 32'(register_id - ID_LOW_FIRST);
          view.mask = 32'h0000_00ff;
        end else if (register_id >= ID_HIGH_FIRST && register_id <= ID_HIGH_LAST) begin
          view.kind  = KIND_GENERAL;
          view.slot  = 32'(register_id - ID_HIGH_FIRST);
          view.mask  = 32'h0000_00ff;
          view.shift = 8;
        end else if (register_id >= ID_SEG_FIRST && register_id <= ID_SEG_LAST) begin
          view.kind = KIND_SEGMENT;
          view.slot = 32'(register_id - ID_SEG_FIRST);
          view.mask = 32'h0000_ffff;
        end

        if (command == CMD_READ) begin
          case (view.kind)
            KIND_GENERAL: lane_bits = (gpr_shadow[view.slot] >> view.shift) & view.mask;
            KIND_SEGMENT: lane_bits = {{(DATA_W-SEG_W){1'b0}}, sreg_shadow[view.slot]};
            default:      lane_bits = '0;
          endcase
          pending_reads.push_back(lane_bits);
        end else begin
          case (view.kind)
            KIND_GENERAL:
              gpr_shadow[view.slot] = (gpr_shadow[view.slot] & ~(view.mask << view.shift))
                                    | ((write_value & view.mask) << view.shift);
            KIND_SEGMENT: sreg_shadow[view.slot] = write_value[SEG_W-1:0];
            default: ;
          endcase
        end
      end

      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_reads.size() != 0)
          report_mismatch($sformatf("%0d read results never arrived", pending_reads.size()));
      end

      reads_in_flight <= pending_reads.size();
    end
  end

endmodule

### bench/tb_x86_partial_register_file_unit.sv
// Testbench top for the partial-register file: clock, reset, stimulus and
// receiver stalls, with the verdict taken from the checker's mismatch count.
// Depends on xprf_pkg, xprf_checker and x86_partial_register_file_unit.
module tb_x86_partial_register_file_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import xprf_pkg::*;

  // This limit leaves ample margin over the slowest correct run, even with
  // the heaviest idling on both sides.
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Register names used by the directed transactions.
  localparam logic [ID_W-1:0] ID_NONE   = 5'd0;
  localparam logic [ID_W-1:0] ID_UNUSED = 5'd31;
  localparam logic [ID_W-1:0] ID_EAX    = ID_DWORD_FIRST;
  localparam logic [ID_W-1:0] ID_EBX    = ID_DWORD_FIRST + 5'd3;
  localparam logic [ID_W-1:0] ID_EDI    = ID_DWORD_LAST;
  localparam logic [ID_W-1:0] ID_AX     = ID_WORD_FIRST;
  localparam logic [ID_W-1:0] ID_DI     = ID_WORD_LAST;
  localparam logic [ID_W-1:0] ID_AL     = ID_LOW_FIRST;
  localparam logic [ID_W-1:0] ID_BL     = ID_LOW_LAST;
  localparam logic [ID_W-1:0] ID_AH     = ID_HIGH_FIRST;
  localparam logic [ID_W-1:0] ID_BH     = ID_HIGH_LAST;
  localparam logic [ID_W-1:0] ID_ES     = ID_SEG_FIRST;
  localparam logic [ID_W-1:0] ID_GS     = ID_SEG_LAST;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              command     = CMD_READ;
  logic [ID_W-1:0]   register_id = '0;
  logic [DATA_W-1:0] write_value = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [DATA_W-1:0] read_value;
  logic              run_done    = 1'b0;

  int unsigned mismatch_count;
  int unsigned reads_in_flight;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  x86_partial_register_file_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .register_id (register_id),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value)
  );

  xprf_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .register_id     (register_id),
    .write_value     (write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_value      (read_value),
    .run_done        (run_done),
    .mismatch_count  (mismatch_count),
    .reads_in_flight (reads_in_flight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver decides afresh at every edge whether to hold off the next
  // result transaction, so stalls land on every phase of the block's work.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offers one transaction, first idling the sender for a random number of
  // cycles, and returns in the time step of the edge at which it is taken.
  // The payload is left alone while in_stall holds it back.
  task automatic issue_access(input logic cmd, input logic [ID_W-1:0] id,
                              input logic [DATA_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    register_id <= id;
    write_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender off until every read result has been delivered. The
  // checker's count is registered, so it is trusted only once that register
  // has been updated with the transaction that was just taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reads_in_flight != 0) @(posedge clk);
  endtask

  // A stretch of random transactions under one idling profile. Halfway
  // through, the sender stops until nothing is outstanding, then carries on.
  task automatic run_phase(input int unsigned count, input int unsigned send_pct,
                           input int unsigned recv_pct);
    logic              cmd;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] value;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_results();
      cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      // Every code the field can carry is drawn, the unused one included.
      id  = ID_W'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0:       value = '0;
        1:       value = '1;
        2:       value = 32'h1 << $urandom_range(0, 31);
        default: value = $urandom();
      endcase
      issue_access(cmd, id, value);
    end
  endtask

  initial begin
    // Synchronous reset first; the block is ready the cycle after its release.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct <= 78;

    // Directed transactions. Reset values first, then the aliasing between a
    // whole register and its halves and bytes, merges that must leave the
    // neighbouring bits alone, the segment width, and finally the none id
    // and the unused code, which must read as zero and swallow writes.
    issue_access(CMD_READ,  ID_EAX,    '0);
    issue_access(CMD_WRITE, ID_EAX,    32'hffff_ffff);
    issue_access(CMD_READ,  ID_AX,     '0);
    issue_access(CMD_READ,  ID_AL,     '0);
    issue_access(CMD_READ,  ID_AH,     '0);
    issue_access(CMD_WRITE, ID_AH,     32'h1234_5600);
    issue_access(CMD_READ,  ID_EAX,    '0);
    issue_access(CMD_WRITE, ID_AL,     32'habcd_ef5a);
    issue_access(CMD_READ,  ID_EAX,    '0);
    issue_access(CMD_WRITE, ID_AX,     32'h0000_a5c3);
    issue_access(CMD_READ,  ID_EAX,    '0);
    issue_access(CMD_WRITE, ID_EDI,    32'h8000_0001);
    issue_access(CMD_READ,  ID_DI,     '0);
    issue_access(CMD_WRITE, ID_BH,     32'hffff_ffff);
    issue_access(CMD_READ,  ID_EBX,    '0);
    issue_access(CMD_READ,  ID_BL,     '0);
    issue_access(CMD_WRITE, ID_GS,     32'hffff_ffff);
    issue_access(CMD_READ,  ID_GS,     '0);
    issue_access(CMD_WRITE, ID_ES,     32'h1234_abcd);
    issue_access(CMD_READ,  ID_ES,     '0);
    issue_access(CMD_WRITE, ID_NONE,   32'hffff_ffff);
    issue_access(CMD_READ,  ID_NONE,   '0);
    issue_access(CMD_WRITE, ID_UNUSED, 32'hffff_ffff);
    issue_access(CMD_READ,  ID_UNUSED, '0);
    issue_access(CMD_READ,  ID_EAX,    '0);

    // Random transactions: a busy receiver, then a slow sender, then both
    // running flat out.
    run_phase(320, 36, 78);
    run_phase(315, 78, 36);
    run_phase(315, 0, 0);

    // Drain, then allow for a last write still being executed.
    wait_for_results();
    repeat (8) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
